// ----- design/nfpa_pkg.sv -----
// ----------------------------------------------------------------------------
// nfpa_pkg: shared definitions of the next-fit port allocator
// Pool geometry, command and status codes, and the word layout of the
// used-slot bitmap that the scan walks one word per cycle.
// ----------------------------------------------------------------------------
package nfpa_pkg;

  localparam int PORT_W    = 16;
  localparam int POOL_SIZE = 256;
  localparam int IDX_W     = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;

  // The bitmap is scanned in words of WORD_W slots.
  localparam int WORD_W    = 16;
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int NUM_WORDS = (POOL_SIZE + WORD_W - 1) / WORD_W;
  localparam int WRD_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int GIDX_W    = WRD_W + BIT_W;
  localparam int CNT_W     = $clog2(NUM_WORDS + 1);

  localparam logic [PORT_W-1:0] PORT_BASE_RESET = 16'd37000;

  localparam logic CMD_ALLOCATE = 1'b0;
  localparam logic CMD_RELEASE  = 1'b1;

  localparam logic [1:0] ST_OK            = 2'd0;
  localparam logic [1:0] ST_NO_FREE       = 2'd1;
  localparam logic [1:0] ST_OUT_OF_RANGE  = 2'd2;
  localparam logic [1:0] ST_NOT_ALLOCATED = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_REL  = 3'b100
  } state_t;

endpackage

// ----- design/next_fit_port_allocator_top.sv -----
// ----------------------------------------------------------------------------
// next_fit_port_allocator_top: next-fit bitmap allocator of port numbers
//
// Input beats arrive on the s_ channel: s_tuser holds the command (allocate
// or release) and s_tdata the port to release. Each command gives exactly one
// result beat on the m_ channel: m_tuser holds the status and m_tdata the
// granted port (zero unless an allocate succeeds). The pool base is written
// through the cfg channel, which is always ready; write it only while idle.
//
// An allocate scans the used-slot bitmap circularly from the next-fit
// pointer, one 16-slot word per cycle through a single masked priority
// encoder. It ends when a free slot is found or the wrap-around pass over
// the first word is done, so its time is set by the number of words visited.
// The block takes one command at a time; s_tready is high only between
// commands.
//
// Reset clears the whole bitmap and the pointer and restores the base to
// 37000. A result waits in the output register while m_tready is low; a
// new command may be accepted meanwhile, and its result is held back until
// the waiting beat has been taken.
// ----------------------------------------------------------------------------
module next_fit_port_allocator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] port
  input  logic [0:0]  s_tuser,   // [0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] granted_port
  output logic [1:0]  m_tuser,   // [1:0] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  nfpa_pkg::state_t state;

  logic [nfpa_pkg::NUM_WORDS-1:0][nfpa_pkg::WORD_W-1:0] used;
  logic [nfpa_pkg::IDX_W-1:0]  search_start;
  logic [nfpa_pkg::PORT_W-1:0] port_base;
  logic [nfpa_pkg::PORT_W-1:0] rel_port;
  logic [nfpa_pkg::WRD_W-1:0]  scan_word;
  logic [nfpa_pkg::CNT_W-1:0]  scan_cnt;

  logic                         out_free;
  logic                         result_load;
  logic [nfpa_pkg::GIDX_W-1:0]  start_g;
  logic [nfpa_pkg::BIT_W-1:0]   start_bit;
  logic [nfpa_pkg::WORD_W-1:0]  scan_mask;
  logic [nfpa_pkg::WORD_W-1:0]  scan_cand;
  logic                         scan_hit;
  logic [nfpa_pkg::BIT_W-1:0]   hit_b;
  logic [nfpa_pkg::GIDX_W-1:0]  hit_g;
  logic [nfpa_pkg::IDX_W-1:0]   hit_idx;
  logic [nfpa_pkg::IDX_W-1:0]   start_next;
  logic                         scan_last;

  logic [nfpa_pkg::PORT_W-1:0]  rel_off;
  logic                         rel_in_range;
  logic [nfpa_pkg::WRD_W-1:0]   rel_w;
  logic [nfpa_pkg::BIT_W-1:0]   rel_b;
  logic                         rel_bit;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == nfpa_pkg::S_IDLE);
  assign out_free  = !m_tvalid || m_tready;

  assign start_g   = nfpa_pkg::GIDX_W'(search_start);
  assign start_bit = start_g[nfpa_pkg::BIT_W-1:0];
  assign scan_last = (scan_cnt == nfpa_pkg::CNT_W'(nfpa_pkg::NUM_WORDS));

  // A result beat is loaded when a scan ends or a release is decided and the
  // output register is free.
  assign result_load = out_free &&
                       (((state == nfpa_pkg::S_SCAN) && (scan_hit || scan_last)) ||
                        (state == nfpa_pkg::S_REL));

  // The first word is searched from the pointer upward; the final pass over
  // the same word covers the slots below the pointer. Padding slots past the
  // end of the pool never qualify.
  always_comb begin
    logic [nfpa_pkg::GIDX_W:0] g;
    for (int b = 0; b < nfpa_pkg::WORD_W; b++) begin
      g = {1'b0, scan_word, nfpa_pkg::BIT_W'(b)};
      if (scan_cnt == '0) begin
        scan_mask[b] = (nfpa_pkg::BIT_W'(b) >= start_bit);
      end else if (scan_last) begin
        scan_mask[b] = (nfpa_pkg::BIT_W'(b) < start_bit);
      end else begin
        scan_mask[b] = 1'b1;
      end
      scan_mask[b] = scan_mask[b] &&
                     (g < (nfpa_pkg::GIDX_W+1)'(nfpa_pkg::POOL_SIZE));
    end
  end

  assign scan_cand = ~used[scan_word] & scan_mask;
  assign scan_hit  = |scan_cand;

  always_comb begin
    hit_b = '0;
    for (int b = nfpa_pkg::WORD_W - 1; b >= 0; b--) begin
      if (scan_cand[b]) begin
        hit_b = nfpa_pkg::BIT_W'(b);
      end
    end
  end

  assign hit_g      = {scan_word, hit_b};
  assign hit_idx    = hit_g[nfpa_pkg::IDX_W-1:0];
  assign start_next = (hit_idx == nfpa_pkg::IDX_W'(nfpa_pkg::POOL_SIZE - 1)) ?
                      '0 : hit_idx + 1'b1;

  // Release: the offset wraps modulo 2^16, so every granted port maps back.
  assign rel_off      = rel_port - port_base;
  assign rel_in_range = (rel_off < nfpa_pkg::PORT_W'(nfpa_pkg::POOL_SIZE));
  assign rel_w        = rel_off[nfpa_pkg::BIT_W +: nfpa_pkg::WRD_W];
  assign rel_b        = rel_off[nfpa_pkg::BIT_W-1:0];
  assign rel_bit      = rel_in_range && used[rel_w][rel_b];

  always_ff @(posedge clk) begin
    if (rst) begin
      port_base <= nfpa_pkg::PORT_BASE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      port_base <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= nfpa_pkg::S_IDLE;
      used         <= '0;
      search_start <= '0;
      m_tvalid     <= 1'b0;
      scan_word    <= '0;
      scan_cnt     <= '0;
    end else begin
      if (result_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        nfpa_pkg::S_IDLE: begin
          if (s_tvalid) begin
            rel_port <= s_tdata;
            if (s_tuser[0] == nfpa_pkg::CMD_RELEASE) begin
              state <= nfpa_pkg::S_REL;
            end else begin
              scan_word <= start_g[nfpa_pkg::GIDX_W-1:nfpa_pkg::BIT_W];
              scan_cnt  <= '0;
              state     <= nfpa_pkg::S_SCAN;
            end
          end
        end
        nfpa_pkg::S_SCAN: begin
          if (scan_hit) begin
            if (out_free) begin
              used[scan_word][hit_b] <= 1'b1;
              search_start <= start_next;
              m_tuser  <= nfpa_pkg::ST_OK;
              m_tdata  <= port_base + nfpa_pkg::PORT_W'(hit_idx);
              state    <= nfpa_pkg::S_IDLE;
            end
          end else if (scan_last) begin
            if (out_free) begin
              m_tuser  <= nfpa_pkg::ST_NO_FREE;
              m_tdata  <= '0;
              state    <= nfpa_pkg::S_IDLE;
            end
          end else begin
            scan_cnt  <= scan_cnt + 1'b1;
            scan_word <= (scan_word == nfpa_pkg::WRD_W'(nfpa_pkg::NUM_WORDS - 1)) ?
                         '0 : scan_word + 1'b1;
          end
        end
        nfpa_pkg::S_REL: begin
          if (out_free) begin
            m_tdata  <= '0;
            if (!rel_in_range) begin
              m_tuser <= nfpa_pkg::ST_OUT_OF_RANGE;
            end else if (!rel_bit) begin
              m_tuser <= nfpa_pkg::ST_NOT_ALLOCATED;
            end else begin
              m_tuser <= nfpa_pkg::ST_OK;
              used[rel_w][rel_b] <= 1'b0;
            end
            state <= nfpa_pkg::S_IDLE;
          end
        end
        default: begin
          state <= nfpa_pkg::S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // The scan never runs past the wrap-around pass over its first word.
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == nfpa_pkg::S_SCAN) |-> (scan_cnt <= nfpa_pkg::CNT_W'(nfpa_pkg::NUM_WORDS)))
    else $error("scan counter past the last word");

  // A granted slot is marked used in the following cycle.
  a_grant_marks: assert property (@(posedge clk) disable iff (rst)
    (state == nfpa_pkg::S_SCAN && scan_hit && out_free)
    |=> used[$past(scan_word)][$past(hit_b)])
    else $error("granted slot not marked used");

  // A successful release frees its slot.
  a_release_frees: assert property (@(posedge clk) disable iff (rst)
    (state == nfpa_pkg::S_REL && out_free && rel_bit)
    |=> !used[$past(rel_w)][$past(rel_b)])
    else $error("released slot still marked used");
`endif

endmodule
